### hdl/spatial_audio_rolloff_gain_defines.svh
// ----------------------------------------------------------------------------
// spatial_audio_rolloff_gain_defines.svh
// Assertion macros used by the rolloff gain top-level design file.
// ----------------------------------------------------------------------------
`ifndef SPATIAL_AUDIO_ROLLOFF_GAIN_DEFINES_SVH
`define SPATIAL_AUDIO_ROLLOFF_GAIN_DEFINES_SVH

// Clocked assertion, quiet while reset is high
`define SARG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define SARG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/sarg_pkg.sv
// ----------------------------------------------------------------------------
// sarg_pkg
// Constants, register indexes and Q1.15 helpers for the rolloff gain block.
// ----------------------------------------------------------------------------
package sarg_pkg;

  localparam int DEF_MAX_POINTS = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int S_DATA_W   = 192;
  localparam int M_DATA_W   = 80;
  localparam int DIST_W     = 25;
  localparam int GAIN_W     = 16;
  localparam int MUL_W      = 26;
  localparam int PROD_W     = 2 * MUL_W;

  localparam logic [15:0] Q_ONE = 16'd32768;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_2D  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_3D  = 3'd4;

  // input kinds
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // clamp a Q1.15 value to 1.0
  function automatic logic [15:0] sat_q(input logic [15:0] x);
    sat_q = (x > Q_ONE) ? Q_ONE : x;
  endfunction

  // round half up a Q1.15 x Q1.15 product back to Q1.15, clamped to 1.0
  function automatic logic [15:0] q_round(input logic [PROD_W-1:0] p);
    logic [PROD_W-1:0] t;
    t = (p + PROD_W'(16384)) >> 15;
    q_round = (t > PROD_W'(Q_ONE)) ? Q_ONE : t[15:0];
  endfunction

endpackage

### hdl/spatial_audio_rolloff_gain.sv
// ----------------------------------------------------------------------------
// spatial_audio_rolloff_gain
// Distance attenuation by a piecewise linear rolloff curve, run by a small
// sequencer around one shared 26x26 multiplier.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser cmd; tdata point and positions
//  m_*      out  m_tvalid/m_tready  tdata vol_2d, vol_3d, atten_gain, distance
//  cfg_*    in   cfg_we             cfg_index, cfg_data
//
// A load item or a disabled evaluate leaves the sequencer idle. An enabled
// evaluate keeps s_tready low through the squares, the bit-serial square root,
// the end-point checks, the binary search, the fetch of the enclosing pair,
// the interpolation product, the divider and final add, and the output products
// and the result load. An empty table skips everything between the square root
// and the products. rst is synchronous and clears the sequencer, m_tvalid and
// the configuration registers; the curve memory is not cleared. The result sits
// in an output register; a finished result waits in the last state for m_tready
// before it overwrites that register.
// ----------------------------------------------------------------------------
`include "spatial_audio_rolloff_gain_defines.svh"

module spatial_audio_rolloff_gain #(
  parameter int MAX_POINTS = sarg_pkg::DEF_MAX_POINTS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // point_index, point_distance, point_gain, src_x, src_y, src_z,
  // lis_x, lis_y, lis_z, zero fill
  input  logic [sarg_pkg::S_DATA_W-1:0]   s_tdata,
  // cmd
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // vol_2d, vol_3d, atten_gain, distance, zero fill
  output logic [sarg_pkg::M_DATA_W-1:0]   m_tdata,
  input  logic                            cfg_we,
  input  logic [sarg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sarg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sarg_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int EW = DIST_W + GAIN_W;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_SQ   = 5'd1;
  localparam logic [4:0] S_SQRT = 5'd2;
  localparam logic [4:0] S_CK0  = 5'd4;
  localparam logic [4:0] S_CKN  = 5'd5;
  localparam logic [4:0] S_SRCH = 5'd6;
  localparam logic [4:0] S_SCMP = 5'd7;
  localparam logic [4:0] S_RLO  = 5'd8;
  localparam logic [4:0] S_RHI  = 5'd9;
  localparam logic [4:0] S_IMUL = 5'd10;
  localparam logic [4:0] S_IDV0 = 5'd11;
  localparam logic [4:0] S_DIV  = 5'd12;
  localparam logic [4:0] S_IADD = 5'd13;
  localparam logic [4:0] S_P1   = 5'd14;
  localparam logic [4:0] S_P2   = 5'd15;
  localparam logic [4:0] S_P3   = 5'd16;
  localparam logic [4:0] S_P4   = 5'd17;
  localparam logic [4:0] S_P5   = 5'd18;
  localparam logic [4:0] S_OUT  = 5'd19;

  // configuration registers
  logic        enable;
  logic [4:0]  num_points;
  logic [15:0] volume, weight_2d, weight_3d;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      num_points <= '0;
      volume     <= Q_ONE;
      weight_2d  <= Q_ONE;
      weight_3d  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:     enable     <= cfg_data[0];
        REG_NUM_POINTS: num_points <= cfg_data[4:0];
        REG_VOLUME:     volume     <= cfg_data;
        REG_WEIGHT_2D:  weight_2d  <= cfg_data;
        REG_WEIGHT_3D:  weight_3d  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input fields
  logic [3:0]        in_idx;
  logic [DIST_W-1:0] in_pdist;
  logic [15:0]       in_pgain;
  logic [23:0]       src_x, src_y, src_z, lis_x, lis_y, lis_z;

  assign in_idx   = s_tdata[3:0];
  assign in_pdist = s_tdata[28:4];
  assign in_pgain = s_tdata[44:29];
  assign src_x    = s_tdata[68:45];
  assign src_y    = s_tdata[92:69];
  assign src_z    = s_tdata[116:93];
  assign lis_x    = s_tdata[140:117];
  assign lis_y    = s_tdata[164:141];
  assign lis_z    = s_tdata[188:165];

  logic [4:0]            state;
  logic [4:0]            cnt;
  logic [DIST_W-1:0]     dx, dy, dz;
  logic [49:0]           acc, bitv, res;
  logic [DIST_W-1:0]     dlen;
  logic [AW-1:0]         lo, hi, mid;
  logic [DIST_W-1:0]     da, db;
  logic [15:0]           ga, gb, gain;
  logic [16:0]           num_lo, quo;
  logic [DIST_W-1:0]     rem;
  logic                  neg;
  logic [15:0]           v2d, v3w, v3d;
  logic [PROD_W-1:0]     mul_p;
  logic signed [MUL_W-1:0] mul_a, mul_b;

  logic accept, is_eval;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign is_eval  = (s_tuser == CMD_EVAL);

  // clamped point count and last index
  logic [31:0]   np32, ncl32, nm1_32;
  logic [NW-1:0] ncl;
  logic [AW-1:0] last_idx;
  assign np32     = 32'(num_points);
  assign ncl32    = (np32 > 32'(MAX_POINTS)) ? 32'(MAX_POINTS) : np32;
  assign ncl      = ncl32[NW-1:0];
  assign nm1_32   = ncl32 - 32'd1;
  assign last_idx = nm1_32[AW-1:0];

  // curve memory: {distance, gain}
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_rdata;
  logic [31:0]   idx32;
  logic [DIST_W-1:0] rd_dist;
  logic [15:0]   rd_gain;

  assign idx32     = 32'(in_idx);
  assign ram_we    = accept && !is_eval && (idx32 < 32'(MAX_POINTS));
  assign ram_waddr = idx32[AW-1:0];
  assign rd_dist   = ram_rdata[EW-1:GAIN_W];
  assign rd_gain   = ram_rdata[GAIN_W-1:0];

  sarg_ram #(.WIDTH(EW), .DEPTH(MAX_POINTS)) u_curve (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({in_pdist, in_pgain}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // search midpoint
  logic [AW:0]   lh_sum;
  logic [AW-1:0] mid_c;
  logic          gap;
  assign lh_sum = {1'b0, lo} + {1'b0, hi};
  assign mid_c  = lh_sum[AW:1];
  assign gap    = ((hi - lo) > AW'(1));

  // read address select
  always_comb begin
    case (state)
      S_SQRT:  ram_raddr = '0;
      S_CK0:   ram_raddr = last_idx;
      S_SRCH:  ram_raddr = gap ? mid_c : lo;
      S_RLO:   ram_raddr = hi;
      default: ram_raddr = mid;
    endcase
  end

  // shared multiplier operand select
  logic signed [16:0] gdiff;
  logic [DIST_W-1:0]  ddiff;
  assign gdiff = $signed({1'b0, gb}) - $signed({1'b0, ga});
  assign ddiff = dlen - da;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQ: begin
        case (cnt)
          5'd0:    begin mul_a = MUL_W'($signed(dx)); mul_b = MUL_W'($signed(dx)); end
          5'd1:    begin mul_a = MUL_W'($signed(dy)); mul_b = MUL_W'($signed(dy)); end
          5'd2:    begin mul_a = MUL_W'($signed(dz)); mul_b = MUL_W'($signed(dz)); end
          default: ;
        endcase
      end
      S_IMUL: begin
        mul_a = MUL_W'(gdiff);
        mul_b = $signed({1'b0, ddiff});
      end
      S_P1: begin
        mul_a = $signed({10'd0, sat_q(volume)});
        mul_b = $signed({10'd0, sat_q(weight_2d)});
      end
      S_P2: begin
        mul_a = $signed({10'd0, sat_q(volume)});
        mul_b = $signed({10'd0, sat_q(weight_3d)});
      end
      S_P4: begin
        mul_a = $signed({10'd0, v3w});
        mul_b = $signed({10'd0, gain});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= PROD_W'(mul_a * mul_b);
  end

  // square root step
  logic [49:0] trial;
  logic        take;
  assign trial = res + bitv;
  assign take  = (acc >= trial);

  // divider step
  logic [DIST_W:0] rem_sh;
  logic            dsub;
  logic [DIST_W-1:0] den;
  assign den    = db - da;
  assign rem_sh = {rem, num_lo[16]};
  assign dsub   = (rem_sh >= {1'b0, den});

  // magnitude of the interpolation product
  logic [PROD_W-1:0] pabs;
  assign pabs = mul_p[PROD_W-1] ? (~mul_p + PROD_W'(1)) : mul_p;

  // interpolated gain
  logic signed [18:0] gsum, qs;
  assign qs   = neg ? -$signed({2'b0, quo}) : $signed({2'b0, quo});
  assign gsum = $signed({3'b0, ga}) + qs;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // output valid: load a finished result, else drop on acceptance
      if (state == S_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && is_eval && enable) begin
            dx    <= DIST_W'($signed(src_x)) - DIST_W'($signed(lis_x));
            dy    <= DIST_W'($signed(src_y)) - DIST_W'($signed(lis_y));
            dz    <= DIST_W'($signed(src_z)) - DIST_W'($signed(lis_z));
            acc   <= '0;
            cnt   <= '0;
            state <= S_SQ;
          end
        end
        // sum of squares, one product per cycle
        S_SQ: begin
          if (cnt != 5'd0) begin
            acc <= acc + mul_p[49:0];
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd3) begin
            res   <= '0;
            bitv  <= 50'd1 << 48;
            state <= S_SQRT;
          end
        end
        // one result bit per cycle
        S_SQRT: begin
          if (take) begin
            acc <= acc - trial;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv <= bitv >> 2;
          if (bitv[0]) begin
            dlen <= take ? DIST_W'((res >> 1) + bitv) : DIST_W'(res >> 1);
            if (ncl == '0) begin
              gain  <= Q_ONE;
              state <= S_P1;
            end else begin
              state <= S_CK0;
            end
          end
        end
        // below the first point
        S_CK0: begin
          if (dlen <= rd_dist) begin
            gain  <= sat_q(rd_gain);
            state <= S_P1;
          end else begin
            state <= S_CKN;
          end
        end
        // above the last point
        S_CKN: begin
          if (dlen >= rd_dist) begin
            gain  <= sat_q(rd_gain);
            state <= S_P1;
          end else begin
            lo    <= '0;
            hi    <= last_idx;
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          mid   <= mid_c;
          state <= gap ? S_SCMP : S_RLO;
        end
        S_SCMP: begin
          if (rd_dist <= dlen) begin
            lo <= mid;
          end else begin
            hi <= mid;
          end
          state <= S_SRCH;
        end
        S_RLO: begin
          da    <= rd_dist;
          ga    <= rd_gain;
          state <= S_RHI;
        end
        S_RHI: begin
          db    <= rd_dist;
          gb    <= rd_gain;
          state <= S_IMUL;
        end
        // non-rising pair takes the gain of the lower point
        S_IMUL: begin
          if (db <= da) begin
            gain  <= sat_q(ga);
            state <= S_P1;
          end else begin
            state <= S_IDV0;
          end
        end
        S_IDV0: begin
          neg    <= mul_p[PROD_W-1];
          rem    <= pabs[41:17];
          num_lo <= pabs[16:0];
          quo    <= '0;
          cnt    <= '0;
          state  <= S_DIV;
        end
        // restoring division, one quotient bit per cycle
        S_DIV: begin
          rem    <= dsub ? DIST_W'(rem_sh - {1'b0, den}) : DIST_W'(rem_sh);
          quo    <= {quo[15:0], dsub};
          num_lo <= {num_lo[15:0], 1'b0};
          cnt    <= cnt + 5'd1;
          if (cnt == 5'd16) begin
            state <= S_IADD;
          end
        end
        S_IADD: begin
          if (gsum < 0) begin
            gain <= '0;
          end else if (gsum > 19'sd32768) begin
            gain <= Q_ONE;
          end else begin
            gain <= gsum[15:0];
          end
          state <= S_P1;
        end
        // output products
        S_P1: state <= S_P2;
        S_P2: begin
          v2d   <= q_round(mul_p);
          state <= S_P3;
        end
        S_P3: begin
          v3w   <= q_round(mul_p);
          state <= S_P4;
        end
        S_P4: state <= S_P5;
        S_P5: begin
          v3d   <= q_round(mul_p);
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {7'd0, dlen, gain, v3d, v2d};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `SARG_ASSERT(a_load_one_cycle,
    (accept && !is_eval) |=> (state == S_IDLE), "load did not finish in one cycle")
  `SARG_ASSERT(a_disabled_quiet,
    (accept && is_eval && !enable) |=> !$rose(m_tvalid), "result from disabled evaluate")
  `SARG_ASSERT(a_gain_range,
    $rose(m_tvalid) |-> (m_tdata[47:32] <= Q_ONE && m_tdata[31:16] <= Q_ONE),
    "gain or 3D volume above unity")
  `SARG_ASSERT_ALWAYS(a_no_accept_busy,
    (state != S_IDLE) |-> !s_tready, "ready while busy")

endmodule

### hdl/sarg_ram.sv
// ----------------------------------------------------------------------------
// sarg_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module sarg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
